@@ rtl/mbp_pkg.sv @@
package mbp_pkg;

    localparam int MAX_BYTES = 4096;

    localparam int CAP_W   = 13;
    localparam int VAL_W   = 32;
    localparam int WIDTH_W = 6;
    localparam int REQ_W   = 2;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 3;
    localparam int BP_W    = $clog2(MAX_BYTES * 8 + 8);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALIGN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] data;
        logic [CNT_W-1:0] count;
        logic [ST_W-1:0]  status;
        logic [CAP_W-1:0] bytes_used;
    } job_t;

    function automatic logic [CAP_W-1:0] used_of(input logic [BP_W-1:0] bp);
        logic [BP_W:0] s;
        s = {1'b0, bp} + (BP_W+1)'(7);
        return CAP_W'(s >> 3);
    endfunction

endpackage

@@ rtl/mbp_ifs.sv @@
interface mbp_req_if;
    logic                          valid;
    logic                          ready;
    logic [mbp_pkg::REQ_W-1:0]     req_type;
    logic [mbp_pkg::VAL_W-1:0]     field_value;
    logic [mbp_pkg::WIDTH_W-1:0]   field_width;

    modport source (output valid, req_type, field_value, field_width, input ready);
    modport sink   (input valid, req_type, field_value, field_width, output ready);
endinterface

interface mbp_res_if;
    logic                          valid;
    logic                          ready;
    logic                          byte_valid;
    logic [7:0]                    data_byte;
    logic [mbp_pkg::ST_W-1:0]      status;
    logic [mbp_pkg::CAP_W-1:0]     bytes_used;
    logic                          last;

    modport source (output valid, byte_valid, data_byte, status, bytes_used, last,
                    input ready);
    modport sink   (input valid, byte_valid, data_byte, status, bytes_used, last,
                    output ready);
endinterface

interface mbp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mbp_pkg::CAP_W-1:0]     capacity_bytes;

    modport source (output valid, capacity_bytes, input ready);
    modport sink   (input valid, capacity_bytes, output ready);
endinterface

@@ rtl/mbp_front.sv @@
module mbp_front (
    input  logic              clk,
    input  logic              rst_n,
    mbp_req_if.sink           req,
    mbp_cfg_if.sink           cfg,
    input  logic              job_ready,
    output logic              job_push,
    output mbp_pkg::job_t     job
);

    logic [mbp_pkg::CAP_W-1:0] cap_reg;
    logic [mbp_pkg::BP_W-1:0]  bp_reg, bp_next;
    logic [6:0]                part_reg, part_next;

    logic [2:0]                      rem;
    logic [mbp_pkg::WIDTH_W-1:0]     w;
    logic                            w_ok;
    logic [mbp_pkg::BP_W:0]          need_sum;
    logic [31:0]                     need32, cap32, max32, eff32;
    logic                            ovf;
    logic [31:0]                     ft;
    logic [39:0]                     word;
    logic [5:0]                      total;
    logic [2:0]                      n;
    logic [7:0]                      sel;
    logic [mbp_pkg::BP_W-1:0]        bp_wr;

    assign req.ready = job_ready;
    assign cfg.ready = 1'b1;
    assign job_push  = req.valid && job_ready;

    assign rem = bp_reg[2:0];
    assign w   = req.field_width;
    assign w_ok = (w != 6'd0) && (w <= 6'd32);

    assign need_sum = {1'b0, bp_reg} + (mbp_pkg::BP_W+1)'(w) + (mbp_pkg::BP_W+1)'(7);
    assign need32   = 32'(need_sum >> 3);
    assign cap32    = 32'(cap_reg);
    assign max32    = 32'(mbp_pkg::MAX_BYTES);
    assign eff32    = (cap32 > max32) ? max32 : cap32;
    assign ovf      = need32 > eff32;

    // top-align the field, then place it right after the partial bits
    assign ft    = req.field_value << (6'd32 - w);
    assign word  = {part_reg, 1'b0, 32'b0} | ({ft, 8'b0} >> rem);
    assign total = {3'b0, rem} + w;
    assign n     = total[5:3];
    assign bp_wr = bp_reg + mbp_pkg::BP_W'(w);

    always_comb
    begin
        unique case (n)
            3'd0:    sel = word[39:32];
            3'd1:    sel = word[31:24];
            3'd2:    sel = word[23:16];
            3'd3:    sel = word[15:8];
            3'd4:    sel = word[7:0];
            default: sel = 8'd0;
        endcase
    end

    always_comb
    begin
        bp_next        = bp_reg;
        part_next      = part_reg;
        job.data       = '0;
        job.count      = '0;
        job.status     = mbp_pkg::ST_OK;
        job.bytes_used = mbp_pkg::used_of(bp_reg);
        unique case (req.req_type)
            mbp_pkg::REQ_WRITE:
            begin
                if (!w_ok)
                begin
                    job.status = mbp_pkg::ST_INVALID;
                end
                else if (ovf)
                begin
                    job.status = mbp_pkg::ST_OVERFLOW;
                end
                else
                begin
                    bp_next        = bp_wr;
                    part_next      = sel[7:1];
                    job.data       = word[39:8];
                    job.count      = n;
                    job.bytes_used = mbp_pkg::used_of(bp_wr);
                end
            end
            mbp_pkg::REQ_ALIGN:
            begin
                if (rem != 3'd0)
                begin
                    bp_next          = bp_reg + mbp_pkg::BP_W'(4'd8 - {1'b0, rem});
                    part_next        = '0;
                    job.data[31:24]  = {part_reg, 1'b0};
                    job.count        = 3'd1;
                end
            end
            mbp_pkg::REQ_START:
            begin
                bp_next        = '0;
                part_next      = '0;
                job.bytes_used = '0;
            end
            default:
            begin
                bp_next = bp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= mbp_pkg::CAP_RESET;
            bp_reg   <= '0;
            part_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                cap_reg <= cfg.capacity_bytes;
            end
            if (job_push)
            begin
                bp_reg   <= bp_next;
                part_reg <= part_next;
            end
        end
    end

endmodule

@@ rtl/mbp_queue.sv @@
module mbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbp_pkg::job_t     push_job,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output mbp_pkg::job_t     head
);

    mbp_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;

    assign full       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/mbp_back.sv @@
module mbp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  mbp_pkg::job_t     head,
    output logic              pop,
    mbp_res_if.source         res
);

    logic [1:0]                  idx_reg;
    logic                        out_valid_reg;
    logic                        byte_valid_reg;
    logic [7:0]                  data_byte_reg;
    logic [mbp_pkg::ST_W-1:0]    status_reg;
    logic [mbp_pkg::CAP_W-1:0]   bytes_used_reg;
    logic                        last_reg;

    logic                        load;
    logic                        has_bytes;
    logic                        is_last;
    logic [7:0]                  cur_byte;

    assign load      = head_valid && (!out_valid_reg || res.ready);
    assign has_bytes = head.count != 3'd0;
    assign is_last   = !has_bytes || ({1'b0, idx_reg} == head.count - 3'd1);
    assign pop       = load && is_last;

    always_comb
    begin
        unique case (idx_reg)
            2'd0: cur_byte = head.data[31:24];
            2'd1: cur_byte = head.data[23:16];
            2'd2: cur_byte = head.data[15:8];
            2'd3: cur_byte = head.data[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_valid_reg <= has_bytes;
            data_byte_reg  <= has_bytes ? cur_byte : 8'd0;
            status_reg     <= head.status;
            bytes_used_reg <= head.bytes_used;
            last_reg       <= is_last;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.byte_valid = byte_valid_reg;
    assign res.data_byte  = data_byte_reg;
    assign res.status     = status_reg;
    assign res.bytes_used = bytes_used_reg;
    assign res.last       = last_reg;

endmodule

@@ rtl/msb_first_bit_packer.sv @@
// packs 1..32-bit fields msb first into bytes; the front takes one request per cycle
// while its two-entry job queue has room, and the back emits one result per cycle from
// a registered output while the consumer is ready; a write that completes n bytes (zero to
// four) yields n results, or one with no byte when n is zero, and every other request one;
// an item's first result passes through the job queue and then the output registers
module msb_first_bit_packer (
    input  logic      clk,
    input  logic      rst_n,
    mbp_req_if.sink   req,
    mbp_cfg_if.sink   cfg,
    mbp_res_if.source res
);

    logic          job_push;
    logic          job_full;
    logic          head_valid;
    logic          pop;
    mbp_pkg::job_t job;
    mbp_pkg::job_t head;

    mbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .job_ready (!job_full),
        .job_push  (job_push),
        .job       (job)
    );

    mbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job),
        .pop        (pop),
        .full       (job_full),
        .head_valid (head_valid),
        .head       (head)
    );

    mbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res        (res)
    );

endmodule
